>>> rtl/pad_button_edge_event_generator_unit_defines.svh
// Assertion macros shared by the button event generator modules.
`ifndef PAD_BUTTON_EDGE_EVENT_GENERATOR_UNIT_DEFINES_SVH
`define PAD_BUTTON_EDGE_EVENT_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PBEG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PBEG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pbeg_pkg.sv
// Shared constants, key map table and types for the button event generator.
package pbeg_pkg;

   // Button vector: 16 digital bits plus two virtual trigger bits.
   localparam int VEC_W          = 18;
   localparam int KEY_COUNT      = 16;
   localparam int KEY_W          = 4;
   localparam int MAP_ENTRIES_DEF = 16;

   // Bit positions inside the button vector.
   localparam int BIT_UP     = 0;
   localparam int BIT_DOWN   = 1;
   localparam int BIT_LEFT   = 2;
   localparam int BIT_RIGHT  = 3;
   localparam int BIT_START  = 4;
   localparam int BIT_BACK   = 5;
   localparam int BIT_LTHUMB = 6;
   localparam int BIT_RTHUMB = 7;
   localparam int BIT_LB     = 8;
   localparam int BIT_RB     = 9;
   localparam int BIT_A      = 12;
   localparam int BIT_B      = 13;
   localparam int BIT_X      = 14;
   localparam int BIT_Y      = 15;
   localparam int BIT_LT     = 16;
   localparam int BIT_RT     = 17;

   // Map entry to button vector bit, in event order.
   localparam int KEY_BIT_POS [KEY_COUNT] = '{
      BIT_LT, BIT_RT, BIT_A, BIT_B, BIT_X, BIT_Y, BIT_BACK, BIT_START,
      BIT_LB, BIT_RB, BIT_LTHUMB, BIT_RTHUMB, BIT_UP, BIT_DOWN, BIT_LEFT, BIT_RIGHT
   };

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_STICK_BIND_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STICK_THRESHOLD   = 2'd2;

   // Register widths and reset values.
   localparam int MODE_W      = 3;
   localparam int TRIG_W      = 8;
   localparam int STICK_THR_W = 15;
   localparam int AXIS_W      = 16;
   localparam logic [TRIG_W-1:0]      TRIG_THR_RST  = 8'd30;
   localparam logic [STICK_THR_W-1:0] STICK_THR_RST = 15'd22000;

   // Stick bind modes; the remaining codes bind nothing.
   localparam logic [MODE_W-1:0] BIND_NONE          = 3'd0;
   localparam logic [MODE_W-1:0] BIND_DPAD          = 3'd1;
   localparam logic [MODE_W-1:0] BIND_FACE          = 3'd2;
   localparam logic [MODE_W-1:0] BIND_SHOULDER      = 3'd3;
   localparam logic [MODE_W-1:0] BIND_SHOULDER_FACE = 3'd4;
   localparam logic [MODE_W-1:0] BIND_DPAD_X        = 3'd5;

   // Stream widths.
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 8;

   // Poll queue between front and back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } back_state_type;

endpackage

>>> rtl/pbeg_front.sv
// Front part: configuration registers, button vector build and change detection.
module pbeg_front #(
   parameter int MAP_ENTRIES = pbeg_pkg::MAP_ENTRIES_DEF,
   localparam int EVT_ENTRIES = (MAP_ENTRIES > pbeg_pkg::KEY_COUNT) ?
                                pbeg_pkg::KEY_COUNT : MAP_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbeg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbeg_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pbeg_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                q_full,
   output logic                                q_push,
   output logic [2*EVT_ENTRIES-1:0]            q_push_data
);

   logic [pbeg_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [pbeg_pkg::TRIG_W-1:0]      trig_thr_ff, trig_thr_in;
   logic [pbeg_pkg::STICK_THR_W-1:0] stick_thr_ff, stick_thr_in;
   logic [pbeg_pkg::VEC_W-1:0]       prev_ff, prev_in;

   logic [15:0]                      button_word;
   logic [pbeg_pkg::TRIG_W-1:0]      left_trigger, right_trigger;
   logic [pbeg_pkg::AXIS_W-1:0]      right_stick_x, right_stick_y;
   logic signed [pbeg_pkg::AXIS_W:0] x_s, y_s, t_pos, t_neg;
   logic                             x_pos, x_neg, y_pos, y_neg;
   logic [pbeg_pkg::VEC_W-1:0]       vec;
   logic [EVT_ENTRIES-1:0]           change, press;
   logic                             accept;

   assign button_word   = req_tdata[15:0];
   assign left_trigger  = req_tdata[23:16];
   assign right_trigger = req_tdata[31:24];
   assign right_stick_x = req_tdata[47:32];
   assign right_stick_y = req_tdata[63:48];

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Register writes; an index beyond the list is dropped.
   always_comb begin
      mode_in      = mode_ff;
      trig_thr_in  = trig_thr_ff;
      stick_thr_in = stick_thr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pbeg_pkg::CSR_STICK_BIND_MODE:   mode_in      = csr_data[pbeg_pkg::MODE_W-1:0];
            pbeg_pkg::CSR_TRIGGER_THRESHOLD: trig_thr_in  = csr_data[pbeg_pkg::TRIG_W-1:0];
            pbeg_pkg::CSR_STICK_THRESHOLD:   stick_thr_in = csr_data;
            default: ;
         endcase
      end
   end

   // Axis classification against +/- threshold, one bit wider to hold -t.
   always_comb begin
      x_s   = signed'({right_stick_x[pbeg_pkg::AXIS_W-1], right_stick_x});
      y_s   = signed'({right_stick_y[pbeg_pkg::AXIS_W-1], right_stick_y});
      t_pos = signed'({2'b00, stick_thr_ff});
      t_neg = -t_pos;
      x_pos = x_s > t_pos;
      x_neg = x_s < t_neg;
      y_pos = y_s > t_pos;
      y_neg = y_s < t_neg;
   end

   always_comb begin
      vec = {2'b00, button_word};
      if (left_trigger > trig_thr_ff) begin
         vec[pbeg_pkg::BIT_LT] = 1'b1;
      end
      if (right_trigger > trig_thr_ff) begin
         vec[pbeg_pkg::BIT_RT] = 1'b1;
      end
      unique case (mode_ff)
         pbeg_pkg::BIND_DPAD: begin
            if (x_pos) vec[pbeg_pkg::BIT_RIGHT] = 1'b1;
            if (x_neg) vec[pbeg_pkg::BIT_LEFT]  = 1'b1;
            if (y_pos) vec[pbeg_pkg::BIT_UP]    = 1'b1;
            if (y_neg) vec[pbeg_pkg::BIT_DOWN]  = 1'b1;
         end
         pbeg_pkg::BIND_FACE: begin
            if (x_pos) vec[pbeg_pkg::BIT_B] = 1'b1;
            if (x_neg) vec[pbeg_pkg::BIT_X] = 1'b1;
            if (y_pos) vec[pbeg_pkg::BIT_Y] = 1'b1;
            if (y_neg) vec[pbeg_pkg::BIT_A] = 1'b1;
         end
         pbeg_pkg::BIND_SHOULDER: begin
            if (x_pos) vec[pbeg_pkg::BIT_RB] = 1'b1;
            if (x_neg) vec[pbeg_pkg::BIT_LB] = 1'b1;
         end
         pbeg_pkg::BIND_SHOULDER_FACE: begin
            if (x_pos) vec[pbeg_pkg::BIT_RB] = 1'b1;
            if (x_neg) vec[pbeg_pkg::BIT_LB] = 1'b1;
            if (y_pos) vec[pbeg_pkg::BIT_Y]  = 1'b1;
            if (y_neg) vec[pbeg_pkg::BIT_A]  = 1'b1;
         end
         pbeg_pkg::BIND_DPAD_X: begin
            if (x_pos) vec[pbeg_pkg::BIT_RIGHT] = 1'b1;
            if (x_neg) vec[pbeg_pkg::BIT_LEFT]  = 1'b1;
         end
         default: ;
      endcase
   end

   // Per map entry: changed since last poll, and its new level.
   for (genvar e = 0; e < EVT_ENTRIES; e++) begin : g_entry
      assign change[e] = vec[pbeg_pkg::KEY_BIT_POS[e]] ^ prev_ff[pbeg_pkg::KEY_BIT_POS[e]];
      assign press[e]  = vec[pbeg_pkg::KEY_BIT_POS[e]];
   end

   assign prev_in     = accept ? vec : prev_ff;
   assign q_push      = accept && (change != '0);
   assign q_push_data = {press, change};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= pbeg_pkg::BIND_NONE;
         trig_thr_ff  <= pbeg_pkg::TRIG_THR_RST;
         stick_thr_ff <= pbeg_pkg::STICK_THR_RST;
         prev_ff      <= '0;
      end else begin
         mode_ff      <= mode_in;
         trig_thr_ff  <= trig_thr_in;
         stick_thr_ff <= stick_thr_in;
         prev_ff      <= prev_in;
      end
   end

endmodule

>>> rtl/pbeg_queue.sv
// Short queue of change and level masks between the front and back parts.
`include "pad_button_edge_event_generator_unit_defines.svh"

module pbeg_queue #(
   parameter int WIDTH = 2 * pbeg_pkg::MAP_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0]             mem_ff [pbeg_pkg::Q_DEPTH];
   logic [pbeg_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pbeg_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pbeg_pkg::Q_CNT_W-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   assign full     = count_ff == pbeg_pkg::Q_CNT_W'(pbeg_pkg::Q_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pbeg_pkg::Q_PTR_W'(pbeg_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pbeg_pkg::Q_PTR_W'(pbeg_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PBEG_ASSERT_NOW(a_no_overflow, push, !full, "poll pushed into a full queue")
   `PBEG_ASSERT_NEXT(a_count_up, push && !full && !(pop && !empty),
      count_ff == $past(count_ff) + 1'b1, "queue count did not advance on push")
   `PBEG_ASSERT_NOW(a_ptr_match, empty || full, wr_ptr_ff == rd_ptr_ff,
      "queue pointers disagree with count")

endmodule

>>> rtl/pbeg_back.sv
// Back part: scan a change mask in map order and emit one event per set entry.
`include "pad_button_edge_event_generator_unit_defines.svh"

module pbeg_back #(
   parameter int MAP_ENTRIES = pbeg_pkg::MAP_ENTRIES_DEF,
   localparam int EVT_ENTRIES = (MAP_ENTRIES > pbeg_pkg::KEY_COUNT) ?
                                pbeg_pkg::KEY_COUNT : MAP_ENTRIES,
   localparam int IDX_W = (EVT_ENTRIES > 1) ? $clog2(EVT_ENTRIES) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  logic [2*EVT_ENTRIES-1:0]           q_data,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pbeg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);

   pbeg_pkg::back_state_type state_ff, state_in;

   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [EVT_ENTRIES-1:0]     remain_ff, remain_in;
   logic [EVT_ENTRIES-1:0]     press_ff, press_in;
   logic                       out_valid_ff, out_valid_in;
   logic [pbeg_pkg::KEY_W-1:0] out_index_ff, out_index_in;
   logic                       out_pressed_ff, out_pressed_in;
   logic                       out_last_ff, out_last_in;

   logic [EVT_ENTRIES-1:0]     remain_clr;
   logic                       out_free, bit_set, step, done, emit;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign bit_set    = remain_ff[idx_ff];
   assign remain_clr = remain_ff & ~(EVT_ENTRIES'(1) << idx_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbeg_pkg::BK_IDLE: if (!q_empty) state_in = pbeg_pkg::BK_SCAN;
         pbeg_pkg::BK_SCAN: if (done)     state_in = pbeg_pkg::BK_IDLE;
         default:                         state_in = pbeg_pkg::BK_IDLE;
      endcase
   end

   // Outputs and datapath control; an unset entry advances even while stalled.
   always_comb begin
      q_pop = 1'b0;
      step  = 1'b0;
      emit  = 1'b0;
      done  = 1'b0;
      unique case (state_ff)
         pbeg_pkg::BK_IDLE: q_pop = !q_empty;
         pbeg_pkg::BK_SCAN: begin
            step = !bit_set || out_free;
            emit = bit_set && out_free;
            done = step && (remain_clr == '0);
         end
         default: ;
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      remain_in = remain_ff;
      press_in  = press_ff;
      if (q_pop) begin
         idx_in    = '0;
         remain_in = q_data[EVT_ENTRIES-1:0];
         press_in  = q_data[2*EVT_ENTRIES-1:EVT_ENTRIES];
      end else if (step) begin
         idx_in    = idx_ff + 1'b1;
         remain_in = remain_clr;
      end
   end

   // Output register: load on emit, drop once taken.
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_index_in   = out_index_ff;
      out_pressed_in = out_pressed_ff;
      out_last_in    = out_last_ff;
      if (emit) begin
         out_valid_in   = 1'b1;
         out_index_in   = pbeg_pkg::KEY_W'(idx_ff);
         out_pressed_in = press_ff[idx_ff];
         out_last_in    = remain_clr == '0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbeg_pkg::BK_IDLE;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      press_ff       <= press_in;
      out_index_ff   <= out_index_in;
      out_pressed_ff <= out_pressed_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(pbeg_pkg::RSP_DATA_W - pbeg_pkg::KEY_W - 1){1'b0}},
                        out_pressed_ff, out_index_ff};
   assign rsp_tlast  = out_last_ff;

   `PBEG_ASSERT_NOW(a_scan_has_work, 1'b1,
      (state_ff == pbeg_pkg::BK_SCAN) == (remain_ff != '0),
      "scan state and pending mask disagree")
   `PBEG_ASSERT_NOW(a_idx_range, state_ff == pbeg_pkg::BK_SCAN,
      idx_ff <= IDX_W'(EVT_ENTRIES - 1), "scan index beyond map")

endmodule

>>> rtl/pad_button_edge_event_generator_unit.sv
// Top level of the gamepad button edge event generator.
//
// Channel   Dir  Handshake              Payload
// -------   ---  ---------------------  ---------------------------------------------
// req_      in   req_tvalid/req_tready  tdata: button_word, left_trigger,
//                                       right_trigger, right_stick_x, right_stick_y
// rsp_      out  rsp_tvalid/rsp_tready  tdata: key_index, key_pressed; tlast: last_event
// csr_      in   csr_valid/csr_ready    csr_index, csr_data (register write)
//
// A poll is classified in the cycle it is accepted; the front takes one poll per
// cycle while the two-entry poll queue has room. Polls that change no mapped
// button leave no trace beyond updating the stored button vector.
// The back scans a queued change mask one map entry per cycle, though a set entry
// waits while the output stalls: it pops the mask in its idle state, then scans
// up to the last set entry, emitting at most one event per cycle.
// A stalled result holds in the output register; scanning of set entries pauses
// meanwhile, and the front keeps accepting polls until the queue fills.
// Reset clears the stored vector to all released and loads register defaults;
// there is no clearing pass. csr_ready is always high.
module pad_button_edge_event_generator_unit #(
   parameter int MAP_ENTRIES = pbeg_pkg::MAP_ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // [15:0] button_word, [23:16] left_trigger, [31:24] right_trigger,
   // [47:32] right_stick_x, [63:48] right_stick_y
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pbeg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [3:0] key_index, [4] key_pressed, [7:5] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pbeg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pbeg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pbeg_pkg::CSR_DATA_W-1:0]    csr_data
);

   // Events exist only for the first sixteen map entries.
   localparam int EVT_ENTRIES = (MAP_ENTRIES > pbeg_pkg::KEY_COUNT) ?
                                pbeg_pkg::KEY_COUNT : MAP_ENTRIES;

   logic                     q_push, q_full, q_pop, q_empty;
   logic [2*EVT_ENTRIES-1:0] q_push_data, q_pop_data;

   // Classify each poll into a change mask and a level mask.
   pbeg_front #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // Decouple classification from event emission.
   pbeg_queue #(
      .WIDTH (2 * EVT_ENTRIES)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // Walk each mask in map order, one event per set entry.
   pbeg_back #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
